// ===== sv/pfe_pkg.sv =====
// ----------------------------------------------------------------------------
// pfe_pkg
// Types, constants and small helper functions for the Playfair digraph
// encryptor: action codes, controller states, letter folding and cell
// row/column arithmetic for the 5x5 square.
// ----------------------------------------------------------------------------
package pfe_pkg;

	localparam int SIDE    = 5;
	localparam int CELLS   = 25;
	localparam int LETTERS = 26;

	localparam logic [4:0] IDX_I    = 5'd8;
	localparam logic [4:0] IDX_J    = 5'd9;
	localparam logic [4:0] IDX_X    = 5'd23;
	localparam logic [4:0] UNPLACED = 5'd25;
	localparam logic [4:0] LAST_IDX = 5'd25;
	localparam logic [4:0] NCELLS   = 5'd25;

	localparam logic [7:0] CHR_LA = 8'h61;
	localparam logic [7:0] CHR_LZ = 8'h7a;
	localparam logic [7:0] CHR_UA = 8'h41;
	localparam logic [7:0] CHR_UZ = 8'h5a;
	localparam logic [6:0] OUT_A  = 7'h61;

	typedef enum logic [1:0] {
		ACT_KEY      = 2'd0,
		ACT_KEY_END  = 2'd1,
		ACT_TEXT     = 2'd2,
		ACT_TEXT_END = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_LOOKUP,
		ST_EMIT0,
		ST_EMIT1
	} state_t;

	// {is_letter, index}; j and J fold to i
	function automatic logic [5:0] letter_of(input logic [7:0] sym);
		logic [7:0] v;
		logic       ok;
		v  = '0;
		ok = 1'b0;
		if (sym >= CHR_LA && sym <= CHR_LZ) begin
			v  = sym - CHR_LA;
			ok = 1'b1;
		end else if (sym >= CHR_UA && sym <= CHR_UZ) begin
			v  = sym - CHR_UA;
			ok = 1'b1;
		end
		if (v[4:0] == IDX_J) begin
			v[4:0] = IDX_I;
		end
		return {ok, v[4:0]};
	endfunction

	function automatic logic [2:0] cell_row(input logic [4:0] p);
		logic [2:0] r;
		if (p >= 5'd20) r = 3'd4;
		else if (p >= 5'd15) r = 3'd3;
		else if (p >= 5'd10) r = 3'd2;
		else if (p >= 5'd5) r = 3'd1;
		else r = 3'd0;
		return r;
	endfunction

	function automatic logic [2:0] cell_col(input logic [4:0] p);
		logic [4:0] base;
		logic [2:0] r;
		r    = cell_row(p);
		base = {r, 2'b00} + {2'b00, r};
		return 3'(p - base);
	endfunction

	function automatic logic [2:0] wrap_inc(input logic [2:0] v);
		return (v == 3'(SIDE - 1)) ? 3'd0 : 3'(v + 3'd1);
	endfunction

	function automatic logic [4:0] cell_of(input logic [2:0] r, input logic [2:0] c);
		return 5'({r, 2'b00} + {2'b00, r} + {2'b00, c});
	endfunction

endpackage

// ===== sv/playfair_digraph_encryptor.sv =====
// ----------------------------------------------------------------------------
// playfair_digraph_encryptor
// Playfair cipher with a 5x5 square held in two small synchronous memories.
//
// Usage: the slave channel carries one action per transaction in s_tuser
// (key letter, key end, text character, text end) with the ASCII byte in
// s_tdata. Key letters are placed in order of arrival; key end walks all 26 letters,
// one per cycle, to fill the square. Text characters are paired;
// the second letter of a pair (or a text end with a letter held) reads the
// position memory, then the square memory, and the pair is emitted as two
// master transactions, m_tlast high on the second. The block takes one
// item at a time: s_tready is low while a fill, a lookup or an emit is
// in progress, and m_tdata holds while m_tready is low.
// Reset clears the letter-placed bits, fill count, square-ready and held
// letter; the square cells hold garbage until the key writes them.
// ----------------------------------------------------------------------------
module playfair_digraph_encryptor (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] symbol
	input  pfe_pkg::action_t s_tuser, // [1:0] action
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [6:0] cipher_letter, [7] zero
	output logic       m_tlast    // pair_last
);
	import pfe_pkg::*;

	state_t state_q, state_d;

	logic [4:0] sq_mem  [CELLS];
	logic [4:0] pos_mem [LETTERS];

	logic [LETTERS-1:0] placed_q;
	logic [4:0] fill_q;
	logic [4:0] scan_q;
	logic       ready_q;
	logic [4:0] held_q;
	logic       held_valid_q;

	logic [5:0] lt;
	logic       lt_ok;
	logic [4:0] lt_idx;
	logic       s_hs;

	logic       wr_en;
	logic [4:0] wr_letter;
	logic       pos_rd_en;
	logic [4:0] rd_a, rd_b;
	logic       held_load, held_clear;
	logic       scan_start, scan_adv, ready_set;

	logic [4:0] pa_raw_s1, pb_raw_s1;
	logic       pa_ok_s1, pb_ok_s1;
	logic [4:0] pa, pb;
	logic [2:0] ra, ca, rb, cb;
	logic [4:0] ea, eb;
	logic       sq_rd_en;
	logic [4:0] qa_s2, qb_s2;
	logic [4:0] cur;

	assign lt     = letter_of(s_tdata);
	assign lt_ok  = lt[5];
	assign lt_idx = lt[4:0];
	assign s_hs   = s_tvalid && s_tready;

	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		m_tvalid   = 1'b0;
		m_tlast    = 1'b0;
		wr_en      = 1'b0;
		wr_letter  = lt_idx;
		pos_rd_en  = 1'b0;
		rd_a       = held_q;
		rd_b       = IDX_X;
		held_load  = 1'b0;
		held_clear = 1'b0;
		scan_start = 1'b0;
		scan_adv   = 1'b0;
		ready_set  = 1'b0;
		sq_rd_en   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_hs) begin
					unique case (s_tuser)
						ACT_KEY: begin
							wr_en = !ready_q && lt_ok && !placed_q[lt_idx] && (fill_q < NCELLS);
						end
						ACT_KEY_END: begin
							if (!ready_q) begin
								scan_start = 1'b1;
								state_d    = ST_FILL;
							end
						end
						ACT_TEXT: begin
							if (ready_q && lt_ok) begin
								if (!held_valid_q) begin
									held_load = 1'b1;
								end else begin
									pos_rd_en = 1'b1;
									if (held_q != lt_idx) begin
										rd_b       = lt_idx;
										held_clear = 1'b1;
									end
									state_d = ST_LOOKUP;
								end
							end
						end
						ACT_TEXT_END: begin
							if (ready_q && held_valid_q) begin
								pos_rd_en  = 1'b1;
								held_clear = 1'b1;
								state_d    = ST_LOOKUP;
							end
						end
						default: ;
					endcase
				end
			end
			ST_FILL: begin
				wr_letter = scan_q;
				wr_en     = (scan_q != IDX_J) && !placed_q[scan_q] && (fill_q < NCELLS);
				scan_adv  = 1'b1;
				if (scan_q == LAST_IDX) begin
					ready_set = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			ST_LOOKUP: begin
				sq_rd_en = 1'b1;
				state_d  = ST_EMIT0;
			end
			ST_EMIT0: begin
				m_tvalid = 1'b1;
				if (m_tready) state_d = ST_EMIT1;
			end
			ST_EMIT1: begin
				m_tvalid = 1'b1;
				m_tlast  = 1'b1;
				if (m_tready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			placed_q     <= '0;
			fill_q       <= '0;
			scan_q       <= '0;
			ready_q      <= 1'b0;
			held_q       <= '0;
			held_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				placed_q[wr_letter] <= 1'b1;
				fill_q              <= fill_q + 5'd1;
			end
			if (scan_start) scan_q <= '0;
			else if (scan_adv) scan_q <= scan_q + 5'd1;
			if (ready_set) ready_q <= 1'b1;
			if (held_load) begin
				held_q       <= lt_idx;
				held_valid_q <= 1'b1;
			end else if (held_clear) begin
				held_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			sq_mem[fill_q]     <= wr_letter;
			pos_mem[wr_letter] <= fill_q;
		end
		if (pos_rd_en) begin
			pa_raw_s1 <= pos_mem[rd_a];
			pb_raw_s1 <= pos_mem[rd_b];
			pa_ok_s1  <= placed_q[rd_a];
			pb_ok_s1  <= placed_q[rd_b];
		end
		if (sq_rd_en) begin
			qa_s2 <= sq_mem[ea];
			qb_s2 <= sq_mem[eb];
		end
	end

	assign pa = (pa_ok_s1 && pa_raw_s1 != UNPLACED) ? pa_raw_s1 : 5'd0;
	assign pb = (pb_ok_s1 && pb_raw_s1 != UNPLACED) ? pb_raw_s1 : 5'd0;
	assign ra = cell_row(pa);
	assign ca = cell_col(pa);
	assign rb = cell_row(pb);
	assign cb = cell_col(pb);

	always_comb begin
		if (ra == rb) begin
			ea = cell_of(ra, wrap_inc(ca));
			eb = cell_of(rb, wrap_inc(cb));
		end else if (ca == cb) begin
			ea = cell_of(wrap_inc(ra), ca);
			eb = cell_of(wrap_inc(rb), cb);
		end else begin
			ea = cell_of(ra, cb);
			eb = cell_of(rb, ca);
		end
	end

	assign cur     = (state_q == ST_EMIT1) ? qb_s2 : qa_s2;
	assign m_tdata = {1'b0, 7'(OUT_A + {2'b00, cur})};

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Playfair digraph encryptor. A scoreboard class
// keeps its own copy of the 5x5 square and the held letter, predicts the
// cipher letters of every accepted transaction and checks each output
// transaction in order. The stimulus covers key building, then directed text
// cases, then random text, with random idle cycles on both sides.
// ----------------------------------------------------------------------------
module tb;
	import pfe_pkg::*;

	typedef struct packed {
		logic [6:0] letter;
		logic       last;
	} cipher_t;

	class cipher_scoreboard;
		logic [4:0] cell_letter [CELLS];
		logic [4:0] letter_cell [LETTERS];
		int         fill_count;
		bit         ready;
		logic [4:0] held;
		bit         held_v;
		cipher_t    cipher_due [$];
		int         mismatches;
		int         letters_taken;

		function new();
			for (int k = 0; k < LETTERS; k++) begin
				letter_cell[k] = UNPLACED;
			end
			for (int k = 0; k < CELLS; k++) begin
				cell_letter[k] = '0;
			end
			fill_count    = 0;
			ready         = 1'b0;
			held          = '0;
			held_v        = 1'b0;
			mismatches    = 0;
			letters_taken = 0;
		endfunction

		function int fold_letter(logic [7:0] sym);
			int v;
			v = -1;
			if (sym >= CHR_LA && sym <= CHR_LZ) begin
				v = int'(sym - CHR_LA);
			end else if (sym >= CHR_UA && sym <= CHR_UZ) begin
				v = int'(sym - CHR_UA);
			end
			if (v == int'(IDX_J)) begin
				v = int'(IDX_I);
			end
			return v;
		endfunction

		function void place_letter(int v);
			if (letter_cell[v] == UNPLACED && fill_count < CELLS) begin
				cell_letter[fill_count] = 5'(v);
				letter_cell[v]          = 5'(fill_count);
				fill_count++;
			end
		endfunction

		function void push_digraph(int a, int b);
			int      pa, pb, ra, ca, rb, cb, ea, eb;
			cipher_t e;
			pa = int'(letter_cell[a]);
			pb = int'(letter_cell[b]);
			ra = pa / SIDE;
			ca = pa % SIDE;
			rb = pb / SIDE;
			cb = pb % SIDE;
			if (ra == rb) begin
				ea = ra * SIDE + (ca + 1) % SIDE;
				eb = rb * SIDE + (cb + 1) % SIDE;
			end else if (ca == cb) begin
				ea = ((ra + 1) % SIDE) * SIDE + ca;
				eb = ((rb + 1) % SIDE) * SIDE + cb;
			end else begin
				ea = ra * SIDE + cb;
				eb = rb * SIDE + ca;
			end
			e.letter = OUT_A + 7'(cell_letter[ea]);
			e.last   = 1'b0;
			cipher_due.push_back(e);
			e.letter = OUT_A + 7'(cell_letter[eb]);
			e.last   = 1'b1;
			cipher_due.push_back(e);
		endfunction

		function void note_item(action_t act, logic [7:0] sym);
			int v;
			v = fold_letter(sym);
			case (act)
				ACT_KEY: begin
					if (!ready && v >= 0) place_letter(v);
				end
				ACT_KEY_END: begin
					if (!ready) begin
						for (int k = 0; k < LETTERS; k++) begin
							if (k != int'(IDX_J)) place_letter(k);
						end
						ready = 1'b1;
					end
				end
				ACT_TEXT: begin
					if (ready && v >= 0) begin
						letters_taken++;
						if (!held_v) begin
							held   = 5'(v);
							held_v = 1'b1;
						end else if (int'(held) == v) begin
							push_digraph(int'(held), int'(IDX_X));
						end else begin
							held_v = 1'b0;
							push_digraph(int'(held), v);
						end
					end
				end
				ACT_TEXT_END: begin
					if (ready && held_v) begin
						letters_taken++;
						held_v = 1'b0;
						push_digraph(int'(held), int'(IDX_X));
					end
				end
			endcase
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			mismatches++;
		endtask

		task check_letter(logic [6:0] letter, logic last);
			cipher_t e;
			if (cipher_due.size() == 0) begin
				report($sformatf("unexpected letter %h last %b", letter, last));
			end else begin
				e = cipher_due.pop_front();
				if (letter !== e.letter)
					report($sformatf("letter got %h want %h", letter, e.letter));
				if (last !== e.last)
					report($sformatf("last got %b want %b", last, e.last));
			end
		endtask
	endclass

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES    = 400;
	localparam int RANDOM_LETTERS = 1250;

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = '0;
	action_t    s_tuser  = ACT_KEY;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tlast;

	cipher_scoreboard sb;
	bit idle_on     = 1'b1;
	bit rx_hold_req = 1'b0;

	playfair_digraph_encryptor u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #4 clk = ~clk;

	function automatic logic [7:0] rand_letter();
		logic [7:0] base;
		base = $urandom_range(1) ? CHR_UA : CHR_LA;
		return base + 8'($urandom_range(25));
	endfunction

	task send_item(input action_t act, input logic [7:0] sym);
		if (idle_on) begin
			while ($urandom_range(99) < 23) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= sym;
		do @(posedge clk); while (!s_tready);
		sb.note_item(act, sym);
	endtask

	task wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.cipher_due.size() != 0) @(posedge clk);
	endtask

	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) sb.check_letter(m_tdata[6:0], m_tlast);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				hold_left   = HOLD_CYCLES;
				m_tready   <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= !(idle_on && $urandom_range(99) < 23);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
			else quiet++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		action_t    act;
		logic [7:0] sym;
		logic [7:0] last_sym;
		int         r;
		int         goal;
		bit         hold_done;
		bit         pause_done;
		sb         = new();
		last_sym   = "a";
		hold_done  = 1'b0;
		pause_done = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// text before the square exists is dropped
		send_item(ACT_TEXT, "a");
		send_item(ACT_TEXT_END, 8'h00);
		// key: uppercase, J folding, non-letters, repeats
		send_item(ACT_KEY, "P");
		send_item(ACT_KEY, "l");
		send_item(ACT_KEY, "A");
		send_item(ACT_KEY, "y");
		send_item(ACT_KEY, "J");
		send_item(ACT_KEY, "!");
		send_item(ACT_KEY, 8'h00);
		send_item(ACT_KEY, 8'hff);
		send_item(ACT_KEY, "a");
		send_item(ACT_KEY, "i");
		repeat (30) begin
			send_item(ACT_KEY, $urandom_range(99) < 60 ? rand_letter() : 8'($urandom_range(255)));
		end
		send_item(ACT_KEY_END, 8'h00);
		// key actions after the square is ready are dropped
		send_item(ACT_KEY, "q");
		send_item(ACT_KEY_END, 8'h00);
		// doubled letters, doubled x, padding, empty text end, j and non-letters
		send_item(ACT_TEXT, "h");
		send_item(ACT_TEXT, "e");
		send_item(ACT_TEXT, "l");
		send_item(ACT_TEXT, "l");
		send_item(ACT_TEXT, "o");
		send_item(ACT_TEXT, "x");
		send_item(ACT_TEXT, "X");
		send_item(ACT_TEXT_END, 8'h00);
		send_item(ACT_TEXT_END, 8'h00);
		send_item(ACT_TEXT, "J");
		send_item(ACT_TEXT, "i");
		send_item(ACT_TEXT, "3");
		send_item(ACT_TEXT, 8'h80);
		send_item(ACT_TEXT, "z");
		send_item(ACT_TEXT, "Z");
		send_item(ACT_TEXT_END, 8'hff);

		goal = sb.letters_taken + RANDOM_LETTERS;
		while (sb.letters_taken < goal) begin
			act = ACT_TEXT;
			r   = $urandom_range(99);
			if (r < 10) sym = last_sym;
			else if (r < 16) sym = $urandom_range(1) ? "x" : "X";
			else if (r < 22) sym = $urandom_range(1) ? "j" : "J";
			else if (r < 80) sym = rand_letter();
			else if (r < 90) sym = 8'($urandom_range(255));
			else if (r < 97) begin
				act = ACT_TEXT_END;
				sym = 8'($urandom_range(255));
			end else begin
				act = $urandom_range(1) ? ACT_KEY : ACT_KEY_END;
				sym = 8'($urandom_range(255));
			end
			if (act == ACT_TEXT) last_sym = sym;
			idle_on = !(sb.letters_taken >= goal - 600 && sb.letters_taken < goal - 300);
			if (!hold_done && sb.letters_taken >= goal - 1200) begin
				hold_done   = 1'b1;
				rx_hold_req = 1'b1;
			end
			if (!pause_done && sb.letters_taken >= goal - 800) begin
				pause_done = 1'b1;
				wait_drained();
			end
			send_item(act, sym);
		end
		idle_on = 1'b1;

		wait_drained();
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0 && sb.cipher_due.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
